FILE: rtl/core/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg: shared types and codes for the double-ended queue
// Request kinds, status codes, word width and the per-cell command beat.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Default number of queue slots
  localparam int unsigned DEPTH_DEF = 16;

  // Word width of queued data
  localparam int unsigned WORD_W = 32;

  // Request kinds
  localparam logic [1:0] KIND_PUSH_BACK  = 2'd0;
  localparam logic [1:0] KIND_PUSH_FRONT = 2'd1;
  localparam logic [1:0] KIND_POP_FRONT  = 2'd2;
  localparam logic [1:0] KIND_POP_BACK   = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Command broadcast to every cell; en is set only for a legal request
  typedef struct packed {
    logic       en;
    logic [1:0] kind;
  } cell_cmd_t;

endpackage

FILE: rtl/core/dq_cell.sv
// ----------------------------------------------------------------------------
// dq_cell: one slot of the shifting queue
// Holds one word and its valid bit; shifts to and from its neighbors and
// forwards the back-word chain toward the front.
// ----------------------------------------------------------------------------
module dq_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dq_pkg::cell_cmd_t               cmd,
  input  logic signed [dq_pkg::WORD_W-1:0] push_value,
  input  logic signed [dq_pkg::WORD_W-1:0] left_data,
  input  logic                            left_valid,
  input  logic signed [dq_pkg::WORD_W-1:0] right_data,
  input  logic                            right_valid,
  input  logic signed [dq_pkg::WORD_W-1:0] tail_in,
  output logic signed [dq_pkg::WORD_W-1:0] data,
  output logic                            valid,
  output logic signed [dq_pkg::WORD_W-1:0] tail_out
);

  logic signed [dq_pkg::WORD_W-1:0] data_r, data_nxt;
  logic                             valid_r, valid_nxt;

  // Next slot contents per request kind
  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (cmd.en) begin
      unique case (cmd.kind)
        dq_pkg::KIND_PUSH_FRONT: begin
          data_nxt  = left_data;
          valid_nxt = left_valid;
        end
        dq_pkg::KIND_PUSH_BACK: begin
          // first free slot takes the new word
          if (!valid_r && left_valid) begin
            data_nxt  = push_value;
            valid_nxt = 1'b1;
          end
        end
        dq_pkg::KIND_POP_FRONT: begin
          data_nxt  = right_data;
          valid_nxt = right_valid;
        end
        dq_pkg::KIND_POP_BACK: begin
          // last occupied slot is released
          if (valid_r && !right_valid) begin
            valid_nxt = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // Back-word chain: only the last occupied slot contributes
  assign tail_out = tail_in | ((valid_r && !right_valid) ? data_r : '0);
  assign data     = data_r;
  assign valid    = valid_r;

endmodule

FILE: rtl/core/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top: bounded double-ended queue of signed words
// Timing: a request is accepted and the cell row updates at that edge; the
//   result beat is then registered in the output register once it is free.
// Flow: one request at a time; the input stalls until the result
//   beat enters the output register, longer while the output is stalled.
// Reset: synchronous active-low; queue empty, no output beat pending.
// ----------------------------------------------------------------------------
module double_ended_queue_top #(
  parameter int unsigned DEPTH = dq_pkg::DEPTH_DEF,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_kind,
  input  logic signed [dq_pkg::WORD_W-1:0] in_push_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [dq_pkg::WORD_W-1:0] out_popped_value,
  output logic                             out_popped_valid,
  output logic signed [dq_pkg::WORD_W-1:0] out_front_value,
  output logic signed [dq_pkg::WORD_W-1:0] out_back_value,
  output logic                             out_is_empty,
  output logic                             out_is_full,
  output logic [CW-1:0]                    out_occupancy,
  output logic [1:0]                       out_status
);

  logic signed [dq_pkg::WORD_W-1:0] cell_data [DEPTH];
  logic                             cell_valid [DEPTH];
  logic signed [dq_pkg::WORD_W-1:0] tail_chain [DEPTH+1];

  dq_pkg::cell_cmd_t cmd;
  logic              accept, is_push, is_full, is_empty, legal, load;

  logic                             busy_r;
  logic [CW-1:0]                    count_r, count_nxt;
  logic signed [dq_pkg::WORD_W-1:0] pend_pop_r;
  logic                             pend_popv_r;
  logic [1:0]                       pend_status_r;

  logic                             out_valid_r;
  logic signed [dq_pkg::WORD_W-1:0] out_popped_value_r, out_front_value_r, out_back_value_r;
  logic                             out_popped_valid_r, out_is_empty_r, out_is_full_r;
  logic [CW-1:0]                    out_occupancy_r;
  logic [1:0]                       out_status_r;

  // Request decode
  assign accept   = in_valid && !busy_r;
  assign in_stall = busy_r;
  assign is_push  = !in_kind[1];
  assign is_full  = (count_r == CW'(DEPTH));
  assign is_empty = (count_r == '0);
  assign legal    = is_push ? !is_full : !is_empty;
  assign cmd.en   = accept && legal;
  assign cmd.kind = in_kind;

  // Row of cells; cell 0 sees the new word as an always-valid left neighbor
  assign tail_chain[DEPTH] = '0;
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [dq_pkg::WORD_W-1:0] l_data, r_data;
    logic                             l_valid, r_valid;
    if (i == 0) begin : g_first
      assign l_data  = in_push_value;
      assign l_valid = 1'b1;
    end else begin : g_mid
      assign l_data  = cell_data[i-1];
      assign l_valid = cell_valid[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_data  = cell_data[i+1];
      assign r_valid = cell_valid[i+1];
    end
    dq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .push_value  (in_push_value),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .right_data  (r_data),
      .right_valid (r_valid),
      .tail_in     (tail_chain[i+1]),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .tail_out    (tail_chain[i])
    );
  end

  // Occupancy update
  always_comb begin
    count_nxt = count_r;
    if (cmd.en) begin
      count_nxt = is_push ? count_r + 1'b1 : count_r - 1'b1;
    end
  end

  // Output register loads once the row has settled
  assign load = busy_r && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        busy_r <= 1'b1;
      end else if (load) begin
        busy_r <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Popped word and status captured at acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_popv_r <= !is_push && legal;
      if (!legal) begin
        pend_pop_r    <= '0;
        pend_status_r <= is_push ? dq_pkg::ST_FULL : dq_pkg::ST_EMPTY;
      end else begin
        pend_status_r <= dq_pkg::ST_DONE;
        if (in_kind == dq_pkg::KIND_POP_FRONT) begin
          pend_pop_r <= cell_data[0];
        end else if (in_kind == dq_pkg::KIND_POP_BACK) begin
          pend_pop_r <= tail_chain[0];
        end else begin
          pend_pop_r <= '0;
        end
      end
    end
  end

  // Result beat
  always_ff @(posedge clk) begin
    if (load) begin
      out_popped_value_r <= pend_pop_r;
      out_popped_valid_r <= pend_popv_r;
      out_status_r       <= pend_status_r;
      out_front_value_r  <= cell_valid[0] ? cell_data[0] : '0;
      out_back_value_r   <= tail_chain[0];
      out_is_empty_r     <= is_empty;
      out_is_full_r      <= is_full;
      out_occupancy_r    <= count_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_popped_value_r;
  assign out_popped_valid = out_popped_valid_r;
  assign out_front_value  = out_front_value_r;
  assign out_back_value   = out_back_value_r;
  assign out_is_empty     = out_is_empty_r;
  assign out_is_full      = out_is_full_r;
  assign out_occupancy    = out_occupancy_r;
  assign out_status       = out_status_r;

endmodule

FILE: rtl/core/dq_checker.sv
// ----------------------------------------------------------------------------
// dq_checker: port-level checks for the double-ended queue
// Watches the request and result beats of the top level; bound below.
// ----------------------------------------------------------------------------
module dq_checker #(
  parameter int unsigned DEPTH = dq_pkg::DEPTH_DEF,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             out_popped_valid,
  input logic signed [dq_pkg::WORD_W-1:0] out_front_value,
  input logic signed [dq_pkg::WORD_W-1:0] out_back_value,
  input logic                             out_is_empty,
  input logic                             out_is_full,
  input logic [CW-1:0]                    out_occupancy,
  input logic [1:0]                       out_status
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_front_value)
      && $stable(out_status))
    else $error("result beat changed while stalled");

  // Empty and full flags agree with occupancy
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_occupancy == '0))
      && (out_is_full == (out_occupancy == CW'(DEPTH))))
    else $error("empty/full flags disagree with occupancy");

  // Empty queue shows zero front and back words
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_front_value == '0 && out_back_value == '0)
    else $error("empty queue shows nonzero words");

  // A successful pop always reports done
  a_pop_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_popped_valid |-> out_status == dq_pkg::ST_DONE)
    else $error("popped word with failing status");

  // One request at a time: the input stalls right after a beat is taken
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken before result formed");

endmodule

bind double_ended_queue_top dq_checker #(.DEPTH(DEPTH)) u_dq_checker (.*);

FILE: tb/tb_double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// tb_double_ended_queue_top: self-checking bench for the double-ended queue
// Sends push/pop requests at both ends and predicts each result beat with
// a shadow ring buffer. Checks every field in order. Random traffic runs in
// push-heavy, pop-heavy and balanced phases so that the full and empty
// corners are hit many times. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_top;

  localparam int unsigned QDEPTH      = dq_pkg::DEPTH_DEF;
  localparam int unsigned OCC_W       = $clog2(QDEPTH + 1);
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          DRAIN_WAIT  = 10;

  // Expected contents of one result beat
  typedef struct packed {
    logic signed [dq_pkg::WORD_W-1:0] popped_value;
    logic                             popped_valid;
    logic signed [dq_pkg::WORD_W-1:0] front_value;
    logic signed [dq_pkg::WORD_W-1:0] back_value;
    logic                             is_empty;
    logic                             is_full;
    logic [OCC_W-1:0]                 occupancy;
    logic [1:0]                       status;
  } dq_result_t;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  logic [1:0]                       in_kind;
  logic signed [dq_pkg::WORD_W-1:0] in_push_value;
  logic                             out_valid;
  logic                             out_stall;
  logic signed [dq_pkg::WORD_W-1:0] out_popped_value;
  logic                             out_popped_valid;
  logic signed [dq_pkg::WORD_W-1:0] out_front_value;
  logic signed [dq_pkg::WORD_W-1:0] out_back_value;
  logic                             out_is_empty;
  logic                             out_is_full;
  logic [OCC_W-1:0]                 out_occupancy;
  logic [1:0]                       out_status;

  // Shadow ring buffer
  logic signed [dq_pkg::WORD_W-1:0] shadow_words [QDEPTH];
  int                               shadow_head;
  int                               shadow_tail;
  int                               shadow_count;

  dq_result_t  expected_beats[$];
  int          error_count = 0;
  int unsigned cycle_count = 0;
  bit          send_burst  = 1'b0;
  bit          recv_burst  = 1'b0;

  double_ended_queue_top #(
    .DEPTH(QDEPTH)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_popped_value (out_popped_value),
    .out_popped_valid (out_popped_valid),
    .out_front_value  (out_front_value),
    .out_back_value   (out_back_value),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full),
    .out_occupancy    (out_occupancy),
    .out_status       (out_status)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d beats outstanding", cycle_count,
               expected_beats.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // One line per mismatch
  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Apply one request to the shadow queue and return the result it yields
  function automatic dq_result_t apply_request(input logic [1:0] kind,
                                               input logic signed [dq_pkg::WORD_W-1:0] word);
    dq_result_t r;
    r = '0;
    r.status = dq_pkg::ST_DONE;
    if (kind == dq_pkg::KIND_PUSH_BACK || kind == dq_pkg::KIND_PUSH_FRONT) begin
      if (shadow_count >= QDEPTH) begin
        r.status = dq_pkg::ST_FULL;
      end else if (kind == dq_pkg::KIND_PUSH_BACK) begin
        shadow_words[shadow_tail] = word;
        shadow_tail = (shadow_tail + 1) % QDEPTH;
        shadow_count++;
      end else begin
        shadow_head = (shadow_head + QDEPTH - 1) % QDEPTH;
        shadow_words[shadow_head] = word;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = dq_pkg::ST_EMPTY;
      end else if (kind == dq_pkg::KIND_POP_FRONT) begin
        r.popped_value = shadow_words[shadow_head];
        r.popped_valid = 1'b1;
        shadow_head = (shadow_head + 1) % QDEPTH;
        shadow_count--;
      end else begin
        shadow_tail = (shadow_tail + QDEPTH - 1) % QDEPTH;
        r.popped_value = shadow_words[shadow_tail];
        r.popped_valid = 1'b1;
        shadow_count--;
      end
    end
    // front/back read zero when empty
    if (shadow_count != 0) begin
      r.front_value = shadow_words[shadow_head];
      r.back_value  = shadow_words[(shadow_tail + QDEPTH - 1) % QDEPTH];
    end
    r.is_empty  = (shadow_count == 0);
    r.is_full   = (shadow_count >= QDEPTH);
    r.occupancy = OCC_W'(shadow_count);
    return r;
  endfunction

  // Data word: extremes and small values mixed into full-range random
  function automatic logic signed [dq_pkg::WORD_W-1:0] random_word();
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return -32'sd1;
      4:       return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // Send one request beat; valid stays up across back-to-back beats
  task automatic send_request(input logic [1:0] kind,
                              input logic signed [dq_pkg::WORD_W-1:0] word);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_push_value <= word;
    @(negedge clk);
    while (in_stall !== 1'b0) @(negedge clk);
    @(posedge clk);
    expected_beats.push_back(apply_request(kind, word));
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  // Compare one result beat against the oldest expectation
  task automatic check_result();
    dq_result_t want;
    if (expected_beats.size() == 0) begin
      report_error("result beat with no request outstanding");
      return;
    end
    want = expected_beats.pop_front();
    if (out_popped_value !== want.popped_value)
      report_error($sformatf("popped_value got %h want %h", out_popped_value,
                             want.popped_value));
    if (out_popped_valid !== want.popped_valid)
      report_error($sformatf("popped_valid got %b want %b", out_popped_valid,
                             want.popped_valid));
    if (out_front_value !== want.front_value)
      report_error($sformatf("front_value got %h want %h", out_front_value,
                             want.front_value));
    if (out_back_value !== want.back_value)
      report_error($sformatf("back_value got %h want %h", out_back_value,
                             want.back_value));
    if (out_is_empty !== want.is_empty)
      report_error($sformatf("is_empty got %b want %b", out_is_empty, want.is_empty));
    if (out_is_full !== want.is_full)
      report_error($sformatf("is_full got %b want %b", out_is_full, want.is_full));
    if (out_occupancy !== want.occupancy)
      report_error($sformatf("occupancy got %0d want %0d", out_occupancy,
                             want.occupancy));
    if (out_status !== want.status)
      report_error($sformatf("status got %0d want %0d", out_status, want.status));
  endtask

  // Result sink: random stall per beat, payload sampled at the falling edge
  initial begin : result_sink
    int hold;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = recv_burst ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(negedge clk);
      while (out_valid !== 1'b1) @(negedge clk);
      check_result();
      @(posedge clk);
    end
  end

  // Pops on an empty queue at both ends
  task automatic test_empty_pops();
    send_burst = 1'b1;
    recv_burst = 1'b0;
    send_request(dq_pkg::KIND_POP_FRONT, random_word());
    send_request(dq_pkg::KIND_POP_BACK, random_word());
  endtask

  // Fill from both ends; the first front push wraps the head index
  task automatic test_fill_both_ends();
    logic signed [dq_pkg::WORD_W-1:0] word;
    send_burst = 1'b0;
    recv_burst = 1'b1;
    for (int i = 0; i < QDEPTH; i++) begin
      case (i)
        0:       word = 32'sh8000_0000;
        1:       word = 32'sh7FFF_FFFF;
        2:       word = '0;
        3:       word = -32'sd1;
        default: word = $urandom;
      endcase
      send_request(i[0] ? dq_pkg::KIND_PUSH_FRONT : dq_pkg::KIND_PUSH_BACK, word);
    end
  endtask

  // Pushes at both ends when full are dropped
  task automatic test_push_when_full();
    send_burst = 1'b0;
    recv_burst = 1'b0;
    send_request(dq_pkg::KIND_PUSH_BACK, 32'sh5555_5555);
    send_request(dq_pkg::KIND_PUSH_FRONT, 32'shAAAA_AAAA);
  endtask

  // One pop from each end of a full queue, then a pause until drained
  task automatic test_pops_with_pause();
    send_burst = 1'b1;
    recv_burst = 1'b1;
    send_request(dq_pkg::KIND_POP_FRONT, random_word());
    send_request(dq_pkg::KIND_POP_BACK, random_word());
    wait_drained();
  endtask

  // Random traffic in phases biased toward push, pop or neither
  task automatic test_random_traffic(input int total);
    int         sent;
    int         seg_len;
    int         push_pct;
    logic [1:0] kind;
    sent = 0;
    while (sent < total) begin
      seg_len = $urandom_range(8, 60);
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      send_burst = ($urandom_range(0, 3) == 0);
      recv_burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < seg_len && sent < total; i++) begin
        if ($urandom_range(1, 100) <= push_pct)
          kind = $urandom_range(0, 1) ? dq_pkg::KIND_PUSH_FRONT : dq_pkg::KIND_PUSH_BACK;
        else
          kind = $urandom_range(0, 1) ? dq_pkg::KIND_POP_FRONT : dq_pkg::KIND_POP_BACK;
        send_request(kind, random_word());
        sent++;
      end
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  // Main sequence
  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_kind       <= dq_pkg::KIND_PUSH_BACK;
    in_push_value <= '0;
    shadow_head    = 0;
    shadow_tail    = 0;
    shadow_count   = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_pops();
    test_fill_both_ends();
    test_push_when_full();
    test_pops_with_pause();
    test_random_traffic(1030);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_beats.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_beats.size()));
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
